// ===== rtl/ltr_pkg.sv =====
// ----------------------------------------------------------------------------
// ltr_pkg
// shared widths, character codes, kind and phase codes and character classes
// for the lexer token recognizer
// ----------------------------------------------------------------------------
`default_nettype none

package ltr_pkg;

    localparam int KIND_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int PHASE_W = 3;
    localparam int LEN_W   = 16;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [LEN_W-1:0]   len_t;

    // token kinds
    localparam kind_t KIND_STRING  = 3'd0;
    localparam kind_t KIND_IDENT   = 3'd1;
    localparam kind_t KIND_SPACE   = 3'd2;
    localparam kind_t KIND_NEWLINE = 3'd3;
    localparam kind_t KIND_NUMBER  = 3'd4;

    // string phases
    localparam phase_t PH_STR_BODY   = 3'd0;
    localparam phase_t PH_STR_ESCAPE = 3'd1;
    // number phases
    localparam phase_t PH_NUM_SIGN  = 3'd0;
    localparam phase_t PH_NUM_POINT = 3'd1;
    localparam phase_t PH_NUM_INT   = 3'd2;
    localparam phase_t PH_NUM_FRAC  = 3'd3;

    // characters
    localparam char_t CH_QUOTE  = 8'h22;
    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_NL     = 8'h0A;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_POINT  = 8'h2E;
    localparam char_t CH_UNDER  = 8'h5F;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_0      = 8'h30;
    localparam char_t CH_9      = 8'h39;
    localparam char_t CH_LC_A   = 8'h61;
    localparam char_t CH_LC_Z   = 8'h7A;
    localparam char_t CH_UC_A   = 8'h41;
    localparam char_t CH_UC_Z   = 8'h5A;

    function automatic logic is_digit(input char_t c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input char_t c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
               ((c >= CH_UC_A) && (c <= CH_UC_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ltr_in_if.sv =====
// ----------------------------------------------------------------------------
// ltr_in_if
// character channel into the token recognizer
// ----------------------------------------------------------------------------
`default_nettype none

interface ltr_in_if;
    logic                valid;
    logic                ready;
    logic                start_req;
    ltr_pkg::kind_t      token_kind;
    ltr_pkg::char_t      char_code;
    logic                end_of_text;

    modport source (
        output valid, start_req, token_kind, char_code, end_of_text,
        input  ready
    );
    modport sink (
        input  valid, start_req, token_kind, char_code, end_of_text,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ltr_out_if.sv =====
// ----------------------------------------------------------------------------
// ltr_out_if
// match length channel out of the token recognizer
// ----------------------------------------------------------------------------
`default_nettype none

interface ltr_out_if;
    logic           valid;
    logic           ready;
    ltr_pkg::len_t  match_length;

    modport source (
        output valid, match_length,
        input  ready
    );
    modport sink (
        input  valid, match_length,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/lexer_token_recognizer.sv =====
// ----------------------------------------------------------------------------
// lexer_token_recognizer
// streaming token length recognizer; while out_ch does not stall, one character per cycle
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one character (or end-of-text mark) per item; an item with
//   start_req set opens a match attempt of kind token_kind at that character.
//   out_ch carries one match_length item per decided attempt, 0 = no match.
//   items outside an attempt, and characters after the decision, give nothing.
// timing:
//   an accepted item lands in the input register; the state update then runs
//   on it and loads the result register, from which the result is shown. one
//   item per cycle is sustained while out_ch does not stall, as the state
//   update between the two registers is combinational.
// stall:
//   while out_ch is stalled with a result waiting, one more item is held in
//   the input register; in_ch.ready drops only when both registers are full.
// reset:
//   rst_n clears the attempt state and both valid flags; no result is pending
//   and no attempt is active after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lexer_token_recognizer #(
    parameter int MAX_LENGTH_BITS = 16
) (
    input  wire     clk,
    input  wire     rst_n,
    ltr_in_if.sink  in_ch,
    ltr_out_if.source out_ch
);

    // counter width: the length saturates at min(2^bits - 1, 65535)
    localparam int CNT_W = (MAX_LENGTH_BITS < ltr_pkg::LEN_W) ?
                           MAX_LENGTH_BITS : ltr_pkg::LEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // input register
    logic                 in_valid_reg;
    logic                 start_reg;
    ltr_pkg::kind_t       kind_in_reg;
    ltr_pkg::char_t       char_reg;
    logic                 eot_reg;

    // attempt state
    logic                 attempt_active_reg, attempt_active_next;
    ltr_pkg::kind_t       kind_held_reg, kind_held_next;
    ltr_pkg::phase_t      phase_reg, phase_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    // result register
    logic                 out_valid_reg;
    ltr_pkg::len_t        out_len_reg;

    logic                 stage_go;
    logic                 res_valid;
    logic [CNT_W-1:0]     res_len;
    logic [CNT_W-1:0]     count_inc;

    assign stage_go    = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || stage_go;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.match_length = out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            start_reg   <= in_ch.start_req;
            kind_in_reg <= in_ch.token_kind;
            char_reg    <= in_ch.char_code;
            eot_reg     <= in_ch.end_of_text;
        end
    end

    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + CNT_ONE;

    always_comb
    begin
        attempt_active_next = attempt_active_reg;
        kind_held_next      = kind_held_reg;
        phase_next          = phase_reg;
        count_next          = count_reg;
        res_valid           = 1'b0;
        res_len             = '0;

        if (start_reg)
        begin
            kind_held_next      = kind_in_reg;
            phase_next          = ltr_pkg::PH_STR_BODY;
            count_next          = '0;
            attempt_active_next = 1'b1;
            if (eot_reg)
            begin
                attempt_active_next = 1'b0;
                res_valid           = 1'b1;
            end
            else
            begin
                unique case (kind_in_reg)
                    ltr_pkg::KIND_STRING:
                    begin
                        if (char_reg != ltr_pkg::CH_QUOTE)
                        begin
                            attempt_active_next = 1'b0;
                            res_valid           = 1'b1;
                        end
                        else
                        begin
                            count_next = CNT_ONE;
                        end
                    end
                    ltr_pkg::KIND_IDENT:
                    begin
                        if (!ltr_pkg::is_alpha(char_reg))
                        begin
                            attempt_active_next = 1'b0;
                            res_valid           = 1'b1;
                        end
                        else
                        begin
                            count_next = CNT_ONE;
                        end
                    end
                    ltr_pkg::KIND_SPACE:
                    begin
                        if (!ltr_pkg::is_blank(char_reg))
                        begin
                            attempt_active_next = 1'b0;
                            res_valid           = 1'b1;
                        end
                        else
                        begin
                            count_next = CNT_ONE;
                        end
                    end
                    ltr_pkg::KIND_NEWLINE:
                    begin
                        attempt_active_next = 1'b0;
                        res_valid           = 1'b1;
                        res_len = (char_reg == ltr_pkg::CH_NL) ? CNT_ONE : '0;
                    end
                    ltr_pkg::KIND_NUMBER:
                    begin
                        // sign, leading point or first digit all count one
                        if (char_reg == ltr_pkg::CH_MINUS)
                        begin
                            count_next = CNT_ONE;
                        end
                        else if (char_reg == ltr_pkg::CH_POINT)
                        begin
                            phase_next = ltr_pkg::PH_NUM_POINT;
                            count_next = CNT_ONE;
                        end
                        else if (ltr_pkg::is_digit(char_reg))
                        begin
                            phase_next = ltr_pkg::PH_NUM_INT;
                            count_next = CNT_ONE;
                        end
                        else
                        begin
                            attempt_active_next = 1'b0;
                            res_valid           = 1'b1;
                        end
                    end
                    default:
                    begin
                        attempt_active_next = 1'b0;
                        res_valid           = 1'b1;
                    end
                endcase
            end
        end
        else if (attempt_active_reg)
        begin
            unique case (kind_held_reg)
                ltr_pkg::KIND_STRING:
                begin
                    priority if (eot_reg)
                    begin
                        attempt_active_next = 1'b0;
                        res_valid           = 1'b1;
                    end
                    else if (phase_reg == ltr_pkg::PH_STR_ESCAPE)
                    begin
                        phase_next = ltr_pkg::PH_STR_BODY;
                        count_next = count_inc;
                    end
                    else if (char_reg == ltr_pkg::CH_BSLASH)
                    begin
                        phase_next = ltr_pkg::PH_STR_ESCAPE;
                        count_next = count_inc;
                    end
                    else if (char_reg == ltr_pkg::CH_QUOTE)
                    begin
                        attempt_active_next = 1'b0;
                        res_valid           = 1'b1;
                        res_len             = count_inc;
                    end
                    else if (char_reg == ltr_pkg::CH_NL)
                    begin
                        attempt_active_next = 1'b0;
                        res_valid           = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                ltr_pkg::KIND_IDENT:
                begin
                    if (eot_reg || !(ltr_pkg::is_alpha(char_reg) ||
                                     ltr_pkg::is_digit(char_reg)))
                    begin
                        attempt_active_next = 1'b0;
                        res_valid           = 1'b1;
                        res_len             = count_reg;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                ltr_pkg::KIND_SPACE:
                begin
                    if (eot_reg || !ltr_pkg::is_blank(char_reg))
                    begin
                        attempt_active_next = 1'b0;
                        res_valid           = 1'b1;
                        res_len             = count_reg;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                ltr_pkg::KIND_NUMBER:
                begin
                    unique case (phase_reg)
                        ltr_pkg::PH_NUM_SIGN:
                        begin
                            priority if (eot_reg)
                            begin
                                attempt_active_next = 1'b0;
                                res_valid           = 1'b1;
                            end
                            else if (char_reg == ltr_pkg::CH_POINT)
                            begin
                                phase_next = ltr_pkg::PH_NUM_POINT;
                                count_next = count_inc;
                            end
                            else if (ltr_pkg::is_digit(char_reg))
                            begin
                                phase_next = ltr_pkg::PH_NUM_INT;
                                count_next = count_inc;
                            end
                            else
                            begin
                                attempt_active_next = 1'b0;
                                res_valid           = 1'b1;
                            end
                        end
                        ltr_pkg::PH_NUM_POINT:
                        begin
                            // a digit must follow a leading point
                            if (eot_reg || !ltr_pkg::is_digit(char_reg))
                            begin
                                attempt_active_next = 1'b0;
                                res_valid           = 1'b1;
                            end
                            else
                            begin
                                phase_next = ltr_pkg::PH_NUM_FRAC;
                                count_next = count_inc;
                            end
                        end
                        ltr_pkg::PH_NUM_INT:
                        begin
                            priority if (eot_reg)
                            begin
                                attempt_active_next = 1'b0;
                                res_valid           = 1'b1;
                                res_len             = count_reg;
                            end
                            else if (char_reg == ltr_pkg::CH_POINT)
                            begin
                                phase_next = ltr_pkg::PH_NUM_FRAC;
                                count_next = count_inc;
                            end
                            else if (!ltr_pkg::is_digit(char_reg))
                            begin
                                attempt_active_next = 1'b0;
                                res_valid           = 1'b1;
                                res_len             = count_reg;
                            end
                            else
                            begin
                                count_next = count_inc;
                            end
                        end
                        default:
                        begin
                            if (eot_reg || !ltr_pkg::is_digit(char_reg))
                            begin
                                attempt_active_next = 1'b0;
                                res_valid           = 1'b1;
                                res_len             = count_reg;
                            end
                            else
                            begin
                                count_next = count_inc;
                            end
                        end
                    endcase
                end
                default:
                begin
                    // kinds that never run past the start character
                    attempt_active_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_active_reg <= 1'b0;
            kind_held_reg      <= '0;
            phase_reg          <= '0;
            count_reg          <= '0;
        end
        else if (stage_go)
        begin
            attempt_active_reg <= attempt_active_next;
            kind_held_reg      <= kind_held_next;
            phase_reg          <= phase_next;
            count_reg          <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && res_valid)
        begin
            out_len_reg <= ltr_pkg::LEN_W'(res_len);
        end
    end

    // a new result only comes from an item held in the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a staged item");

    // a decided attempt is closed
    a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && res_valid) |=> !attempt_active_reg)
        else $error("attempt still active after its result");

    // input backs up only when both registers are full and the output stalls
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (in_valid_reg && out_valid_reg && !out_ch.ready))
        else $error("input stalled without cause");

    // reported length never exceeds the saturation cap
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_len_reg <= ltr_pkg::LEN_W'(CNT_MAX)))
        else $error("match length above cap");

endmodule

`default_nettype wire
